// ===== hdl/rle16_pkg.sv =====
// rle16_pkg: shared constants, command and state types for the 16-bit word rle compressor
// used by rle16_front, rle16_cmd_fifo, rle16_back and the top level
`timescale 1ns / 1ps
`default_nettype none

package rle16_pkg;

   // field widths and limits
   localparam int WORD_W          = 16;
   localparam int COUNT_W         = 15;
   localparam int MAX_LITERAL_DEF = 32;
   localparam int MAX_REPEAT      = 32767;
   localparam int CMD_DEPTH       = 4;

   // header bit that marks a repeat block
   localparam logic [WORD_W-1:0] REPEAT_FLAG = 16'h8000;

   typedef logic [WORD_W-1:0] word_type;

   typedef enum logic {
      CMD_LITERAL,
      CMD_REPEAT
   } cmd_kind_type;

   // one block to be written out by the back end
   typedef struct packed {
      cmd_kind_type        kind;
      logic [COUNT_W-1:0]  count;
      word_type            value;
      logic                last;
   } cmd_type;

   // literal buffer write from the front end
   typedef struct packed {
      logic     en;
      word_type data;
   } lit_wr_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_REPEAT_FLUSH,
      FRONT_FINAL,
      FRONT_FINAL_ZERO
   } front_state_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_REPEAT_VALUE,
      BACK_LITERAL
   } back_state_type;

endpackage

`default_nettype wire

// ===== hdl/rle16_front.sv =====
// rle16_front: accepts input words, tracks the lookahead word and open runs,
// writes literal words to the buffer and issues block commands; uses rle16_pkg
`timescale 1ns / 1ps
`default_nettype none

module rle16_front #(
   parameter int MAX_LITERAL = rle16_pkg::MAX_LITERAL_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // input word channel
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire rle16_pkg::word_type  req_word,
   input  wire logic                 req_final,
   // command queue
   input  wire logic                 cmd_full,
   output logic                      cmd_push,
   output rle16_pkg::cmd_type        cmd_data,
   // literal buffer
   output rle16_pkg::lit_wr_type     lit_wr,
   input  wire logic                 lit_consumed
);

   localparam int CNT_W     = $clog2(MAX_LITERAL + 1);
   localparam int LIT_AW    = $clog2(MAX_LITERAL) + 1;
   localparam int OCC_W     = LIT_AW + 1;
   localparam int LIT_DEPTH = 1 << LIT_AW;
   localparam int COUNT_W   = rle16_pkg::COUNT_W;

   rle16_pkg::front_state_type state_ff, state_in;
   rle16_pkg::word_type        held_ff, held_in;
   logic                       held_valid_ff, held_valid_in;
   rle16_pkg::word_type        rep_val_ff, rep_val_in;
   logic [COUNT_W-1:0]         rep_cnt_ff, rep_cnt_in;
   logic                       in_repeat_ff, in_repeat_in;
   logic [CNT_W-1:0]           lit_cnt_ff, lit_cnt_in;
   logic                       fin_ff, fin_in;
   logic [OCC_W-1:0]           occ_ff, occ_in;

   logic accept;
   logic lit_room;
   logic starts_repeat;
   logic split_flush;
   logic rep_cap_one;
   logic [CNT_W-1:0] lit_cnt_inc;

   // handshake and shared decisions
   assign lit_room      = (occ_ff != OCC_W'(LIT_DEPTH));
   assign req_tready    = (state_ff == rle16_pkg::FRONT_IDLE) && !cmd_full && lit_room;
   assign accept        = req_tvalid && req_tready;
   assign rep_cap_one   = (rle16_pkg::MAX_REPEAT <= 1);
   assign starts_repeat = !in_repeat_ff && held_valid_ff && (held_ff == req_word);
   assign split_flush   = starts_repeat && (lit_cnt_ff != '0) && rep_cap_one;
   assign lit_cnt_inc   = lit_cnt_ff + CNT_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rle16_pkg::FRONT_IDLE: begin
            if (accept) begin
               if (split_flush) begin
                  state_in = rle16_pkg::FRONT_REPEAT_FLUSH;
               end else if (req_final) begin
                  state_in = rle16_pkg::FRONT_FINAL;
               end
            end
         end
         rle16_pkg::FRONT_REPEAT_FLUSH: begin
            if (!cmd_full) begin
               state_in = fin_ff ? rle16_pkg::FRONT_FINAL : rle16_pkg::FRONT_IDLE;
            end
         end
         rle16_pkg::FRONT_FINAL: begin
            if (!cmd_full && lit_room) begin
               if (!in_repeat_ff && held_valid_ff && (held_ff == '0) &&
                   (lit_cnt_ff != '0)) begin
                  state_in = rle16_pkg::FRONT_FINAL_ZERO;
               end else begin
                  state_in = rle16_pkg::FRONT_IDLE;
               end
            end
         end
         rle16_pkg::FRONT_FINAL_ZERO: begin
            if (!cmd_full) begin
               state_in = rle16_pkg::FRONT_IDLE;
            end
         end
         default: state_in = rle16_pkg::FRONT_IDLE;
      endcase
   end

   // run tracking, literal writes and commands
   always_comb begin
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      rep_val_in    = rep_val_ff;
      rep_cnt_in    = rep_cnt_ff;
      in_repeat_in  = in_repeat_ff;
      lit_cnt_in    = lit_cnt_ff;
      fin_in        = fin_ff;
      cmd_push      = 1'b0;
      cmd_data      = '{kind: rle16_pkg::CMD_LITERAL, count: COUNT_W'(lit_cnt_ff),
                        value: rep_val_ff, last: 1'b0};
      lit_wr        = '{en: 1'b0, data: held_ff};
      case (state_ff)
         rle16_pkg::FRONT_IDLE: begin
            if (accept) begin
               fin_in = req_final;
               if (in_repeat_ff) begin
                  // extend the open run or close it
                  if ((req_word == rep_val_ff) &&
                      (rep_cnt_ff < COUNT_W'(rle16_pkg::MAX_REPEAT))) begin
                     rep_cnt_in = rep_cnt_ff + COUNT_W'(1);
                  end else begin
                     cmd_push      = 1'b1;
                     cmd_data.kind = rle16_pkg::CMD_REPEAT;
                     cmd_data.count = rep_cnt_ff;
                     in_repeat_in  = 1'b0;
                     held_in       = req_word;
                     held_valid_in = 1'b1;
                  end
               end else if (held_valid_ff) begin
                  if (held_ff == req_word) begin
                     // pair found: close pending literals and open a run
                     if (lit_cnt_ff != '0) begin
                        cmd_push      = 1'b1;
                        lit_cnt_in    = '0;
                        in_repeat_in  = 1'b1;
                        rep_val_in    = held_ff;
                        held_valid_in = 1'b0;
                        if (rep_cap_one) begin
                           rep_cnt_in = COUNT_W'(1);
                           held_in    = req_word;
                        end else begin
                           rep_cnt_in = COUNT_W'(2);
                        end
                     end else if (rep_cap_one) begin
                        cmd_push       = 1'b1;
                        cmd_data.kind  = rle16_pkg::CMD_REPEAT;
                        cmd_data.count = COUNT_W'(1);
                        cmd_data.value = held_ff;
                        held_in        = req_word;
                     end else begin
                        in_repeat_in  = 1'b1;
                        rep_val_in    = held_ff;
                        rep_cnt_in    = COUNT_W'(2);
                        held_valid_in = 1'b0;
                     end
                  end else begin
                     // held word becomes a literal
                     lit_wr.en = 1'b1;
                     held_in   = req_word;
                     if (lit_cnt_inc == CNT_W'(MAX_LITERAL)) begin
                        cmd_push       = 1'b1;
                        cmd_data.count = COUNT_W'(lit_cnt_inc);
                        lit_cnt_in     = '0;
                     end else begin
                        lit_cnt_in = lit_cnt_inc;
                     end
                  end
               end else begin
                  held_in       = req_word;
                  held_valid_in = 1'b1;
               end
            end
         end
         rle16_pkg::FRONT_REPEAT_FLUSH: begin
            if (!cmd_full) begin
               cmd_push       = 1'b1;
               cmd_data.kind  = rle16_pkg::CMD_REPEAT;
               cmd_data.count = rep_cnt_ff;
               in_repeat_in   = 1'b0;
               held_valid_in  = 1'b1;
            end
         end
         rle16_pkg::FRONT_FINAL: begin
            if (!cmd_full && lit_room) begin
               cmd_push      = 1'b1;
               cmd_data.last = 1'b1;
               in_repeat_in  = 1'b0;
               held_valid_in = 1'b0;
               lit_cnt_in    = '0;
               if (in_repeat_ff) begin
                  cmd_data.kind  = rle16_pkg::CMD_REPEAT;
                  cmd_data.count = rep_cnt_ff;
               end else if (held_valid_ff && (held_ff != '0)) begin
                  // last word joins the literal block
                  lit_wr.en      = 1'b1;
                  cmd_data.count = COUNT_W'(lit_cnt_inc);
               end else if (held_valid_ff) begin
                  // last word of zero: single repeat block, after any literals
                  if (lit_cnt_ff != '0) begin
                     cmd_data.last = 1'b0;
                     held_valid_in = 1'b1;
                  end else begin
                     cmd_data.kind  = rle16_pkg::CMD_REPEAT;
                     cmd_data.count = COUNT_W'(1);
                     cmd_data.value = '0;
                  end
               end
            end
         end
         rle16_pkg::FRONT_FINAL_ZERO: begin
            if (!cmd_full) begin
               cmd_push       = 1'b1;
               cmd_data.kind  = rle16_pkg::CMD_REPEAT;
               cmd_data.count = COUNT_W'(1);
               cmd_data.value = '0;
               cmd_data.last  = 1'b1;
               held_valid_in  = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // words in the literal buffer not yet sent
   assign occ_in = occ_ff + OCC_W'(lit_wr.en) - OCC_W'(lit_consumed);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rle16_pkg::FRONT_IDLE;
         held_valid_ff <= 1'b0;
         in_repeat_ff  <= 1'b0;
         lit_cnt_ff    <= '0;
         occ_ff        <= '0;
         fin_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_valid_ff <= held_valid_in;
         in_repeat_ff  <= in_repeat_in;
         lit_cnt_ff    <= lit_cnt_in;
         occ_ff        <= occ_in;
         fin_ff        <= fin_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      held_ff    <= held_in;
      rep_val_ff <= rep_val_in;
      rep_cnt_ff <= rep_cnt_in;
   end

endmodule

`default_nettype wire

// ===== hdl/rle16_cmd_fifo.sv =====
// rle16_cmd_fifo: short queue of block commands between front and back end
// uses rle16_pkg for the command type and depth
`timescale 1ns / 1ps
`default_nettype none

module rle16_cmd_fifo (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire rle16_pkg::cmd_type  push_data,
   input  wire logic                pop,
   output rle16_pkg::cmd_type       head,
   output logic                     full,
   output logic                     empty
);

   localparam int AW = $clog2(rle16_pkg::CMD_DEPTH);

   rle16_pkg::cmd_type entries_ff [rle16_pkg::CMD_DEPTH];
   logic [AW:0] wr_ptr_ff, wr_ptr_in;
   logic [AW:0] rd_ptr_ff, rd_ptr_in;

   // pointer compare with wrap bit
   assign empty = (wr_ptr_ff == rd_ptr_ff);
   assign full  = (wr_ptr_ff[AW-1:0] == rd_ptr_ff[AW-1:0]) && (wr_ptr_ff[AW] != rd_ptr_ff[AW]);
   assign head  = entries_ff[rd_ptr_ff[AW-1:0]];

   assign wr_ptr_in = wr_ptr_ff + (AW+1)'(push && !full);
   assign rd_ptr_in = rd_ptr_ff + (AW+1)'(pop && !empty);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push && !full) begin
         entries_ff[wr_ptr_ff[AW-1:0]] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/rle16_back.sv =====
// rle16_back: holds the literal buffer and turns block commands into code words
// with a registered output stage; uses rle16_pkg
`timescale 1ns / 1ps
`default_nettype none

module rle16_back #(
   parameter int MAX_LITERAL = rle16_pkg::MAX_LITERAL_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // command queue
   input  wire logic                   cmd_empty,
   input  wire rle16_pkg::cmd_type     cmd_head,
   output logic                        cmd_pop,
   // literal buffer
   input  wire rle16_pkg::lit_wr_type  lit_wr,
   output logic                        lit_consumed,
   // code word channel
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output rle16_pkg::word_type         rsp_code,
   output logic                        rsp_end
);

   localparam int CNT_W     = $clog2(MAX_LITERAL + 1);
   localparam int LIT_AW    = $clog2(MAX_LITERAL) + 1;
   localparam int LIT_DEPTH = 1 << LIT_AW;

   rle16_pkg::back_state_type state_ff, state_in;
   rle16_pkg::word_type       lit_mem [LIT_DEPTH];
   rle16_pkg::word_type       rdata_ff;
   logic [LIT_AW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [LIT_AW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]          remain_ff, remain_in;
   rle16_pkg::word_type       value_ff, value_in;
   logic                      last_ff, last_in;
   logic                      out_valid_ff, out_valid_in;
   rle16_pkg::word_type       out_code_ff, out_code_in;
   logic                      out_end_ff, out_end_in;
   logic                      can_load;
   logic                      emit;

   assign can_load   = !out_valid_ff || rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_code   = out_code_ff;
   assign rsp_end    = out_end_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rle16_pkg::BACK_IDLE: begin
            if (!cmd_empty && can_load) begin
               state_in = (cmd_head.kind == rle16_pkg::CMD_REPEAT) ?
                          rle16_pkg::BACK_REPEAT_VALUE : rle16_pkg::BACK_LITERAL;
            end
         end
         rle16_pkg::BACK_REPEAT_VALUE: begin
            if (can_load) begin
               state_in = rle16_pkg::BACK_IDLE;
            end
         end
         rle16_pkg::BACK_LITERAL: begin
            if (can_load && (remain_ff == CNT_W'(1))) begin
               state_in = rle16_pkg::BACK_IDLE;
            end
         end
         default: state_in = rle16_pkg::BACK_IDLE;
      endcase
   end

   // word selection and counters
   always_comb begin
      emit         = 1'b0;
      cmd_pop      = 1'b0;
      lit_consumed = 1'b0;
      out_code_in  = out_code_ff;
      out_end_in   = out_end_ff;
      remain_in    = remain_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      case (state_ff)
         rle16_pkg::BACK_IDLE: begin
            if (!cmd_empty && can_load) begin
               // header word
               emit       = 1'b1;
               cmd_pop    = 1'b1;
               out_end_in = 1'b0;
               value_in   = cmd_head.value;
               last_in    = cmd_head.last;
               remain_in  = CNT_W'(cmd_head.count);
               if (cmd_head.kind == rle16_pkg::CMD_REPEAT) begin
                  out_code_in = rle16_pkg::REPEAT_FLAG | {1'b0, cmd_head.count};
               end else begin
                  out_code_in = {1'b0, cmd_head.count};
               end
            end
         end
         rle16_pkg::BACK_REPEAT_VALUE: begin
            if (can_load) begin
               emit        = 1'b1;
               out_code_in = value_ff;
               out_end_in  = last_ff;
            end
         end
         rle16_pkg::BACK_LITERAL: begin
            if (can_load) begin
               emit         = 1'b1;
               lit_consumed = 1'b1;
               out_code_in  = rdata_ff;
               out_end_in   = last_ff && (remain_ff == CNT_W'(1));
               remain_in    = remain_ff - CNT_W'(1);
            end
         end
         default: ;
      endcase
   end

   assign out_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   assign wr_ptr_in    = wr_ptr_ff + LIT_AW'(lit_wr.en);
   assign rd_ptr_in    = rd_ptr_ff + LIT_AW'(lit_consumed);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rle16_pkg::BACK_IDLE;
         out_valid_ff <= 1'b0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      out_code_ff <= out_code_in;
      out_end_ff  <= out_end_in;
      remain_ff   <= remain_in;
      value_ff    <= value_in;
      last_ff     <= last_in;
   end

   // literal buffer, read one word ahead of the output
   always_ff @(posedge clock) begin
      if (lit_wr.en) begin
         lit_mem[wr_ptr_ff] <= lit_wr.data;
      end
      rdata_ff <= lit_mem[rd_ptr_in];
   end

endmodule

`default_nettype wire

// ===== hdl/rle16_word_compressor.sv =====
// rle16_word_compressor: run-length encoder for a stream of 16-bit words
// top level; instantiates rle16_front, rle16_cmd_fifo and rle16_back, uses rle16_pkg
//
// Usage: data words enter on the req_ channel, the last word of a stream marked by
// req_tlast. Code words leave on the rsp_ channel: a header (bit 15 set for a repeat
// block, low 15 bits the count) followed by the value (repeat) or the words (literal).
// rsp_tlast marks the last code word of a stream.
// One word of lookahead is held, so codes for a word appear only once the next word
// (or the end of the stream) has arrived. A non-final word is taken when the command
// queue and the literal buffer have room; after the final word the front end flushes
// the open runs in a final state, and in a second state for a last zero after literals.
// The back end sends one code word per cycle while blocks are queued and rsp_tready
// is high: a repeat block is a header and the value, a literal block a header and the
// count words, from a buffer of 2 x MAX_LITERAL words rounded up to a power of two.
// When rsp_tready is low the output register holds its word; the front end keeps
// taking words until the command queue (4 blocks) or the literal buffer fills.
// Reset (synchronous) empties the queue and buffer and starts a new stream.
`timescale 1ns / 1ps
`default_nettype none

module rle16_word_compressor #(
   parameter int MAX_LITERAL = rle16_pkg::MAX_LITERAL_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [15:0]  req_tdata,   // [15:0] word
   input  wire logic         req_tlast,   // final_req
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [15:0]       rsp_tdata,   // [15:0] code
   output logic              rsp_tlast    // stream_end
);

   logic                  cmd_push;
   rle16_pkg::cmd_type    cmd_in;
   rle16_pkg::cmd_type    cmd_head;
   logic                  cmd_pop;
   logic                  cmd_full;
   logic                  cmd_empty;
   rle16_pkg::lit_wr_type lit_wr;
   logic                  lit_consumed;

   // classification and run tracking
   rle16_front #(
      .MAX_LITERAL (MAX_LITERAL)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_word     (req_tdata),
      .req_final    (req_tlast),
      .cmd_full     (cmd_full),
      .cmd_push     (cmd_push),
      .cmd_data     (cmd_in),
      .lit_wr       (lit_wr),
      .lit_consumed (lit_consumed)
   );

   // block command queue
   rle16_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .pop       (cmd_pop),
      .head      (cmd_head),
      .full      (cmd_full),
      .empty     (cmd_empty)
   );

   // code word generation
   rle16_back #(
      .MAX_LITERAL (MAX_LITERAL)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_empty    (cmd_empty),
      .cmd_head     (cmd_head),
      .cmd_pop      (cmd_pop),
      .lit_wr       (lit_wr),
      .lit_consumed (lit_consumed),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_code     (rsp_tdata),
      .rsp_end      (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== hdl/rle16_checker.sv =====
// rle16_checker: port-level assertions for rle16_word_compressor
// bound to the top level at the end of this file; no package use
`timescale 1ns / 1ps
`default_nettype none

module rle16_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [15:0] req_tdata,
   input wire logic        req_tlast,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic        rsp_tlast
);

   // a stalled code word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   // reset empties the output stage
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // reset leaves the block ready for a new stream
   assert property (@(posedge clock) reset |=> req_tready)
      else $error("req not ready after reset");

   // the final word is followed by a flush before the next word is taken
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("word taken during end-of-stream flush");

   // an offered input word waits unchanged until it is taken
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata) && $stable(req_tlast))
      else $error("req word changed while waiting");

endmodule

bind rle16_word_compressor rle16_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ===== tb/rle16_word_compressor_tb.sv =====
// rle16_word_compressor_tb: self-checking bench for the 16-bit word rle compressor
// predicts every code word from the accepted input words; needs rle16_pkg and the top level
`timescale 1ns / 1ps

module rle16_word_compressor_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_LIMIT = 20000;
   localparam int TAIL_CYCLES = 16;

   typedef struct {
      rle16_pkg::word_type code;
      bit                  stream_end;
   } code_word_type;

   // bench signals
   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   rle16_pkg::word_type req_tdata  = '0;
   logic                req_tlast  = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   rle16_pkg::word_type rsp_tdata;
   logic                rsp_tlast;

   // run control and statistics
   int idle_pct      = 0;
   int stall_pct     = 0;
   int hold_request  = 0;
   int hold_left     = 0;
   int cycle_count   = 0;
   int error_count   = 0;
   int words_taken   = 0;
   int streams_taken = 0;
   int codes_checked = 0;

   // encoder state mirrored by the predictor
   code_word_type       expected_codes[$];
   rle16_pkg::word_type lit_buf [rle16_pkg::MAX_LITERAL_DEF];
   int                  lit_cnt;
   rle16_pkg::word_type la_word;
   bit                  la_valid;
   rle16_pkg::word_type run_value;
   int                  run_len;
   bit                  run_open;

   rle16_word_compressor DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [15:0] word
      .req_tlast  (req_tlast),    // final_req
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [15:0] code
      .rsp_tlast  (rsp_tlast)     // stream_end
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic void clear_encoder();
      lit_cnt   = 0;
      la_word   = '0;
      la_valid  = 1'b0;
      run_value = '0;
      run_len   = 0;
      run_open  = 1'b0;
   endfunction

   function automatic void put_code(input rle16_pkg::word_type c);
      code_word_type e;
      e.code       = c;
      e.stream_end = 1'b0;
      expected_codes.insert(expected_codes.size(), e);
   endfunction

   // literal block: header with count, then the pending words
   function automatic void flush_literal_block();
      if (lit_cnt == 0)
         return;
      put_code(rle16_pkg::word_type'(lit_cnt & 32'h7FFF));
      for (int i = 0; i < lit_cnt && i < rle16_pkg::MAX_LITERAL_DEF; i++)
         put_code(lit_buf[i]);
      lit_cnt = 0;
   endfunction

   // repeat block: flagged header with count, then the value
   function automatic void close_run();
      put_code(rle16_pkg::REPEAT_FLAG | rle16_pkg::word_type'(run_len & 32'h7FFF));
      put_code(run_value);
      run_open = 1'b0;
      run_len  = 0;
   endfunction

   function automatic void add_literal(input rle16_pkg::word_type v);
      if (lit_cnt < rle16_pkg::MAX_LITERAL_DEF)
         lit_buf[lit_cnt] = v;
      lit_cnt++;
      // full literal block goes out at once
      if (lit_cnt >= rle16_pkg::MAX_LITERAL_DEF)
         flush_literal_block();
   endfunction

   // classify the lookahead word against the new word
   function automatic void take_word(input rle16_pkg::word_type w);
      if (!run_open && la_valid) begin
         if (la_word == w) begin
            flush_literal_block();
            run_open  = 1'b1;
            run_value = la_word;
            run_len   = 1;
            la_valid  = 1'b0;
         end else begin
            add_literal(la_word);
            la_word = w;
            return;
         end
      end
      if (run_open) begin
         if (w == run_value && run_len < rle16_pkg::MAX_REPEAT) begin
            run_len++;
            return;
         end
         // capped or broken run, the word is classified afresh
         close_run();
      end
      la_word  = w;
      la_valid = 1'b1;
   endfunction

   function automatic void predict_codes(input rle16_pkg::word_type w, input bit fin);
      take_word(w);
      if (!fin)
         return;
      if (run_open) begin
         close_run();
      end else if (la_valid) begin
         // last held word meets a zero pad: a zero becomes a one-word repeat
         if (la_word == '0) begin
            flush_literal_block();
            run_value = '0;
            run_len   = 1;
            close_run();
         end else begin
            add_literal(la_word);
            flush_literal_block();
         end
         la_valid = 1'b0;
      end
      flush_literal_block();
      if (expected_codes.size() > 0)
         expected_codes[expected_codes.size() - 1].stream_end = 1'b1;
      clear_encoder();
   endfunction

   initial clear_encoder();

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("ERROR at %0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      error_count++;
   endtask

   // predict on every accepted word, compare every accepted code word
   always @(posedge clock) begin : code_check
      code_word_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_codes(req_tdata, req_tlast);
            words_taken++;
            if (req_tlast)
               streams_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_codes.size() == 0) begin
               report_mismatch("code word with none expected", rsp_tdata, 0);
            end else begin
               want = expected_codes.pop_front();
               if (rsp_tdata !== want.code)
                  report_mismatch("code", rsp_tdata, want.code);
               if (rsp_tlast !== want.stream_end)
                  report_mismatch("stream_end", rsp_tlast, want.stream_end);
               codes_checked++;
            end
         end
      end
   end

   // receiver ready, with a long hold-off on request
   always @(posedge clock) begin : rsp_ready_drive
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ERROR: timeout after %0d cycles", cycle_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   // offer one word, with random idle cycles ahead of it, and wait for the handshake
   task automatic send_word(input rle16_pkg::word_type w, input bit fin);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   task automatic send_stream(input rle16_pkg::word_type words[$]);
      for (int i = 0; i < words.size(); i++)
         send_word(words[i], i == words.size() - 1);
   endtask

   // stop offering and wait until every predicted code word has arrived
   task automatic wait_all_results();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      // let the last accepted word reach the predictor first
      @(posedge clock);
      while (expected_codes.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_codes.size() != 0) begin
         report_mismatch("code words never delivered", expected_codes.size(), 0);
         expected_codes.delete();
      end
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // zero and small values often, so runs and the zero tail show up
   function automatic rle16_pkg::word_type pick_word();
      case ($urandom_range(3))
         0:       return '0;
         1:       return rle16_pkg::word_type'($urandom_range(3));
         default: return rle16_pkg::word_type'($urandom_range(65535));
      endcase
   endfunction

   // stream built from runs and single words with random content
   task automatic send_random_stream(input int max_len);
      rle16_pkg::word_type words[$];
      rle16_pkg::word_type v;
      int                  len;
      int                  k;
      len = $urandom_range(max_len, 1);
      while (words.size() < len) begin
         v = pick_word();
         k = ($urandom_range(2) == 0) ? $urandom_range(6, 2) : 1;
         for (int i = 0; i < k && words.size() < len; i++)
            words.insert(words.size(), v);
      end
      send_stream(words);
   endtask

   // ---------------------------------------------------------------- tests

   // short streams: single words, zero tail, runs, field extremes
   task automatic test_directed_edges();
      idle_pct  = 0;
      stall_pct = 0;
      send_stream('{16'h0000});
      send_stream('{16'hFFFF});
      send_stream('{16'h1234, 16'h0000});
      send_stream('{16'h0007, 16'h0007, 16'h0007});
      send_stream('{16'h0008, 16'h0008, 16'h0009});
      send_stream('{16'hFFFF, 16'hFFFF, 16'h0001, 16'h8000});
      send_stream('{16'h5555, 16'hAAAA});
      send_stream('{16'h0000, 16'h0000});
      wait_all_results();
   endtask

   // more distinct words than one literal block holds
   task automatic test_literal_cap();
      rle16_pkg::word_type words[$];
      for (int i = 0; i < 2 * rle16_pkg::MAX_LITERAL_DEF + 3; i++)
         words.insert(words.size(), rle16_pkg::word_type'(16'h0100 + i));
      send_stream(words);
      wait_all_results();
   endtask

   task automatic test_random_phase(input int sender_idle, input int receiver_stall,
                                    input int word_target);
      int start;
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      start     = words_taken;
      while (words_taken - start < word_target)
         send_random_stream(($urandom_range(7) == 0) ? 48 : 16);
   endtask

   // receiver holds off while the sender keeps going, so the block fills up
   task automatic test_backpressure();
      rle16_pkg::word_type words[$];
      rle16_pkg::word_type v;
      idle_pct  = 0;
      stall_pct = 0;
      hold_request = 300;
      for (int i = 0; i < 25; i++) begin
         v = rle16_pkg::word_type'($urandom_range(65535));
         words.insert(words.size(), v);
         words.insert(words.size(), v);
      end
      send_stream(words);
      wait_all_results();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_edges();
      test_literal_cap();
      test_random_phase(0, 0, 40);
      test_random_phase(64, 0, 40);
      wait_all_results();
      test_random_phase(0, 64, 40);
      test_random_phase(27, 27, 40);
      test_backpressure();
      wait_all_results();

      $display("Run covered %0d words in %0d streams and %0d checked code words,",
               words_taken, streams_taken, codes_checked);
      $display("including full literal blocks, zero tails and a long output stall");
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
